>>> rtl/abta_pkg.sv
// ----------------------------------------------------------------------------
// abta_pkg
// Shared widths, codes and controller/datapath command types for the
// boundary-tag arena allocator.
// ----------------------------------------------------------------------------
package abta_pkg;

   localparam int CMD_W       = 2;
   localparam int REQ_BYTES_W = 17;
   localparam int ADDR_W      = 16;
   localparam int SZ_W        = 17;
   localparam int TAG_W       = 18;
   localparam int IDX_W       = 18;
   localparam int FREE_BIT    = 17;
   localparam int TAG_BYTES   = 8;
   localparam int MAX_ROUNDED = 131064;

   localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COALESCE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESET    = 2'd3;

   // read address sources
   localparam logic [1:0] RD_H     = 2'd0;
   localparam logic [1:0] RD_HM1   = 2'd1;
   localparam logic [1:0] RD_RDATA = 2'd2;
   localparam logic [1:0] RD_NXT   = 2'd3;

   // write operations
   localparam logic [2:0] WR_NONE  = 3'd0;
   localparam logic [2:0] WR_A_HDR = 3'd1;
   localparam logic [2:0] WR_A_FTR = 3'd2;
   localparam logic [2:0] WR_FREE  = 3'd3;
   localparam logic [2:0] WR_HDR   = 3'd4;
   localparam logic [2:0] WR_FTR   = 3'd5;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic [1:0] rd_src;
      logic [2:0] wr_op;
      logic       ld_w;
      logic       ld_p;
      logic       merge_prev;
      logic       merge_next;
      logic       alloc_ok;
      logic       bump;
      logic       set_fail;
      logic       clr_front;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic fits;
      logic h_nonzero;
      logic prev_free;
      logic next_merge;
   } dp_status_type;

endpackage

>>> rtl/abta_if.sv
// ----------------------------------------------------------------------------
// abta_req_if / abta_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface abta_req_if;
   logic                               valid;
   logic                               ready;
   logic [abta_pkg::CMD_W-1:0]         cmd;
   logic [abta_pkg::REQ_BYTES_W-1:0]   req_bytes;
   logic [abta_pkg::ADDR_W-1:0]        block_addr;

   modport source (output valid, output cmd, output req_bytes, output block_addr,
                   input ready);
   modport sink   (input valid, input cmd, input req_bytes, input block_addr,
                   output ready);
endinterface

interface abta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [abta_pkg::ADDR_W-1:0]   payload_addr;
   logic [abta_pkg::SZ_W-1:0]     block_bytes;

   modport source (output valid, output status, output payload_addr, output block_bytes,
                   input ready);
   modport sink   (input valid, input status, input payload_addr, input block_bytes,
                   output ready);
endinterface

>>> rtl/arena_boundary_tag_allocator.sv
// ----------------------------------------------------------------------------
// arena_boundary_tag_allocator
// Bump arena with boundary tags: allocate, mark free, coalesce, reset arena.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    cmd, req_bytes, block_addr
//   rsp_chan  out  valid/ready    status, payload_addr, block_bytes
//
// One transaction at a time, set by the serial tag memory reads and writes.
// Allocate checks room, then writes header and footer; mark free reads the
// header and writes it back marked free; coalesce merges with a free previous
// and next block; the response register loads in the last state of each one.
// A finished response waits in the output register; the next transaction is
// accepted meanwhile and stalls only at its own completion.
// Reset clears the frontier and control; tag words are not cleared.
// ----------------------------------------------------------------------------
module arena_boundary_tag_allocator #(
   parameter int ARENA_UNITS = 8192
) (
   input  logic              clock,
   input  logic              reset,
   abta_req_if.sink          req_chan,
   abta_rsp_if.source        rsp_chan
);

   abta_pkg::dp_cmd_type    dp_cmd;
   abta_pkg::dp_status_type dp_status;

   abta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   abta_dp #(
      .ARENA_UNITS (ARENA_UNITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_bytes        (req_chan.req_bytes),
      .block_addr       (req_chan.block_addr),
      .out_status       (rsp_chan.status),
      .out_payload_addr (rsp_chan.payload_addr),
      .out_block_bytes  (rsp_chan.block_bytes)
   );

endmodule

>>> rtl/abta_dp.sv
// ----------------------------------------------------------------------------
// abta_dp
// Datapath: tag memory, frontier, working registers and response register.
// ----------------------------------------------------------------------------
module abta_dp #(
   parameter int ARENA_UNITS = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  abta_pkg::dp_cmd_type             cmd,
   output abta_pkg::dp_status_type          status,
   input  logic [abta_pkg::REQ_BYTES_W-1:0] req_bytes,
   input  logic [abta_pkg::ADDR_W-1:0]      block_addr,
   output logic                             out_status,
   output logic [abta_pkg::ADDR_W-1:0]      out_payload_addr,
   output logic [abta_pkg::SZ_W-1:0]        out_block_bytes
);

   localparam int AW    = (ARENA_UNITS > 1) ? $clog2(ARENA_UNITS) : 1;
   localparam int LIMIT = ARENA_UNITS * abta_pkg::TAG_BYTES;
   localparam int FW    = $clog2(LIMIT + 1);
   localparam int CW    = ((FW > abta_pkg::IDX_W) ? FW : abta_pkg::IDX_W) + 1;
   localparam int NW    = abta_pkg::IDX_W + 3;
   localparam int IW    = abta_pkg::IDX_W;
   localparam int SW    = abta_pkg::SZ_W;
   localparam int TW    = abta_pkg::TAG_W;

   logic [TW-1:0] mem [ARENA_UNITS];
   logic [TW-1:0] q_ff;
   logic          rd_ok_ff;

   logic [FW-1:0] frontier_ff, frontier_in;
   logic [abta_pkg::REQ_BYTES_W-1:0] req_ff, req_in;
   logic [IW-1:0] h_ff, h_in;
   logic [TW-1:0] w_ff, w_in;
   logic [SW-1:0] sz_ff, sz_in;
   logic [SW-1:0] p_ff, p_in;
   logic          st_ff, st_in;
   logic [abta_pkg::ADDR_W-1:0] pay_ff, pay_in;
   logic          o_st_ff;
   logic [abta_pkg::ADDR_W-1:0] o_pay_ff;
   logic [SW-1:0] o_bytes_ff;

   logic [TW-1:0] rd_word;
   logic [SW-1:0] rd_size;
   logic [IW-1:0] rounded_raw, rounded, hw, nxt, rd_addr, wr_addr;
   logic [TW-1:0] wr_data;
   logic          wr_en;
   logic [CW-1:0] need;

   assign rd_word = rd_ok_ff ? q_ff : '0;
   assign rd_size = rd_word[SW-1:0];

   assign rounded_raw = IW'(req_ff) + IW'(7);
   assign rounded     = {rounded_raw[IW-1:3], 3'b000};
   assign hw          = IW'(frontier_ff >> 3);
   assign nxt         = h_ff + IW'(2) + IW'(sz_ff >> 3);
   assign need        = CW'(frontier_ff) + CW'(rounded) + CW'(2 * abta_pkg::TAG_BYTES);

   assign status.fits       = (rounded <= IW'(abta_pkg::MAX_ROUNDED)) && (need <= CW'(LIMIT));
   assign status.h_nonzero  = (h_ff != '0);
   assign status.prev_free  = rd_word[abta_pkg::FREE_BIT];
   assign status.next_merge = rd_word[abta_pkg::FREE_BIT] && ({nxt, 3'b000} < NW'(frontier_ff));

   always_comb begin
      case (cmd.rd_src)
         abta_pkg::RD_H:     rd_addr = h_ff;
         abta_pkg::RD_HM1:   rd_addr = h_ff - IW'(1);
         abta_pkg::RD_RDATA: rd_addr = IW'(rd_size);
         abta_pkg::RD_NXT:   rd_addr = nxt;
         default:            rd_addr = h_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = h_ff;
      wr_data = {w_ff[abta_pkg::FREE_BIT], sz_ff};
      case (cmd.wr_op)
         abta_pkg::WR_A_HDR: begin
            wr_addr = hw;
            wr_data = TW'(rounded);
         end
         abta_pkg::WR_A_FTR: begin
            wr_addr = hw + IW'(1) + (rounded >> 3);
            wr_data = TW'(hw);
         end
         abta_pkg::WR_FREE: begin
            wr_addr = h_ff;
            wr_data = w_ff | (TW'(1) << abta_pkg::FREE_BIT);
         end
         abta_pkg::WR_HDR: begin
            wr_addr = h_ff;
            wr_data = {w_ff[abta_pkg::FREE_BIT], sz_ff};
         end
         abta_pkg::WR_FTR: begin
            wr_addr = h_ff + IW'(1) + IW'(sz_ff >> 3);
            wr_data = TW'(h_ff);
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr < IW'(ARENA_UNITS))) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         q_ff     <= mem[rd_addr[AW-1:0]];
         rd_ok_ff <= (rd_addr < IW'(ARENA_UNITS));
      end
   end

   always_comb begin
      req_in      = cmd.load_req ? req_bytes : req_ff;
      h_in        = h_ff;
      w_in        = w_ff;
      sz_in       = sz_ff;
      p_in        = cmd.ld_p ? rd_size : p_ff;
      st_in       = st_ff;
      pay_in      = pay_ff;
      frontier_in = frontier_ff;
      if (cmd.load_req) begin
         h_in   = IW'(block_addr[abta_pkg::ADDR_W-1:3]);
         sz_in  = '0;
         st_in  = 1'b0;
         pay_in = '0;
      end
      if (cmd.ld_w) begin
         w_in  = rd_word;
         sz_in = rd_size;
      end
      if (cmd.merge_prev) begin
         w_in  = rd_word;
         h_in  = IW'(p_ff);
         sz_in = rd_size + SW'(2 * abta_pkg::TAG_BYTES) + sz_ff;
      end
      if (cmd.merge_next) begin
         sz_in = sz_ff + SW'(2 * abta_pkg::TAG_BYTES) + rd_size;
      end
      if (cmd.alloc_ok) begin
         sz_in  = SW'(rounded);
         pay_in = abta_pkg::ADDR_W'(CW'(frontier_ff) + CW'(abta_pkg::TAG_BYTES));
      end
      if (cmd.set_fail) begin
         st_in = 1'b1;
      end
      if (cmd.bump) begin
         frontier_in = FW'(need);
      end
      if (cmd.clr_front) begin
         frontier_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frontier_ff <= '0;
      end else begin
         frontier_ff <= frontier_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      h_ff   <= h_in;
      w_ff   <= w_in;
      sz_ff  <= sz_in;
      p_ff   <= p_in;
      st_ff  <= st_in;
      pay_ff <= pay_in;
      if (cmd.out_load) begin
         o_st_ff    <= st_ff;
         o_pay_ff   <= pay_ff;
         o_bytes_ff <= sz_ff;
      end
   end

   assign out_status       = o_st_ff;
   assign out_payload_addr = o_pay_ff;
   assign out_block_bytes  = o_bytes_ff;

endmodule

>>> rtl/abta_ctrl.sv
// ----------------------------------------------------------------------------
// abta_ctrl
// Command sequencer: walks each transaction through tag reads and writes and
// hands the result to the response register.
// ----------------------------------------------------------------------------
module abta_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [abta_pkg::CMD_W-1:0]   req_cmd,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output abta_pkg::dp_cmd_type         cmd,
   input  abta_pkg::dp_status_type      status
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_A_HDR = 5'd1;
   localparam logic [4:0] S_A_FTR = 5'd2;
   localparam logic [4:0] S_F_RD  = 5'd3;
   localparam logic [4:0] S_F_LD  = 5'd4;
   localparam logic [4:0] S_F_WR  = 5'd5;
   localparam logic [4:0] S_C_RH  = 5'd6;
   localparam logic [4:0] S_C_W   = 5'd7;
   localparam logic [4:0] S_C_P   = 5'd8;
   localparam logic [4:0] S_C_PW  = 5'd9;
   localparam logic [4:0] S_C_PH  = 5'd10;
   localparam logic [4:0] S_C_PF  = 5'd11;
   localparam logic [4:0] S_C_NX  = 5'd12;
   localparam logic [4:0] S_C_NW  = 5'd13;
   localparam logic [4:0] S_C_NH  = 5'd14;
   localparam logic [4:0] S_C_NF  = 5'd15;
   localparam logic [4:0] S_CLR   = 5'd16;
   localparam logic [4:0] S_DONE  = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = abta_pkg::RD_H;
      cmd.wr_op  = abta_pkg::WR_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_cmd)
                  abta_pkg::CMD_ALLOC:    state_in = S_A_HDR;
                  abta_pkg::CMD_FREE:     state_in = S_F_RD;
                  abta_pkg::CMD_COALESCE: state_in = S_C_RH;
                  default:                state_in = S_CLR;
               endcase
            end
         end
         S_A_HDR: begin
            if (status.fits) begin
               cmd.wr_op    = abta_pkg::WR_A_HDR;
               cmd.alloc_ok = 1'b1;
               state_in     = S_A_FTR;
            end else begin
               cmd.set_fail = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_A_FTR: begin
            cmd.wr_op = abta_pkg::WR_A_FTR;
            cmd.bump  = 1'b1;
            state_in  = S_DONE;
         end
         S_F_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_F_LD;
         end
         S_F_LD: begin
            cmd.ld_w = 1'b1;
            state_in = S_F_WR;
         end
         S_F_WR: begin
            cmd.wr_op = abta_pkg::WR_FREE;
            state_in  = S_DONE;
         end
         S_C_RH: begin
            cmd.rd_en = 1'b1;
            state_in  = S_C_W;
         end
         S_C_W: begin
            cmd.ld_w = 1'b1;
            if (status.h_nonzero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = abta_pkg::RD_HM1;
               state_in   = S_C_P;
            end else begin
               state_in = S_C_NX;
            end
         end
         S_C_P: begin
            cmd.ld_p   = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_src = abta_pkg::RD_RDATA;
            state_in   = S_C_PW;
         end
         S_C_PW: begin
            if (status.prev_free) begin
               cmd.merge_prev = 1'b1;
               state_in       = S_C_PH;
            end else begin
               state_in = S_C_NX;
            end
         end
         S_C_PH: begin
            cmd.wr_op = abta_pkg::WR_HDR;
            state_in  = S_C_PF;
         end
         S_C_PF: begin
            cmd.wr_op = abta_pkg::WR_FTR;
            state_in  = S_C_NX;
         end
         S_C_NX: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = abta_pkg::RD_NXT;
            state_in   = S_C_NW;
         end
         S_C_NW: begin
            if (status.next_merge) begin
               cmd.merge_next = 1'b1;
               state_in       = S_C_NH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_C_NH: begin
            cmd.wr_op = abta_pkg::WR_HDR;
            state_in  = S_C_NF;
         end
         S_C_NF: begin
            cmd.wr_op = abta_pkg::WR_FTR;
            state_in  = S_DONE;
         end
         S_CLR: begin
            cmd.clr_front = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/abta_checker.sv
// ----------------------------------------------------------------------------
// abta_checker
// Port-level checks on the allocator response channel.
// ----------------------------------------------------------------------------
module abta_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_status,
   input logic [abta_pkg::ADDR_W-1:0]       rsp_payload_addr,
   input logic [abta_pkg::SZ_W-1:0]         rsp_block_bytes
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_payload_addr) && $stable(rsp_block_bytes))
      else $error("stalled response changed");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_payload_addr == '0 && rsp_block_bytes == '0)
      else $error("failed allocate carries nonzero fields");

   a_pay_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_addr[2:0] == 3'b000)
      else $error("payload address not 8-byte aligned");

endmodule

bind arena_boundary_tag_allocator abta_checker u_abta_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_payload_addr (rsp_chan.payload_addr),
   .rsp_block_bytes  (rsp_chan.block_bytes)
);
